FILE: design/assert_macros.svh
// Assertion macros for the substring replace stream unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define SRS_ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: assertion failed");

`define SRS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

`define SRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`else

`define SRS_ASSERT_ALWAYS(lbl, clk, rst_n, prop)

`define SRS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)

`define SRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: design/srs_pkg.sv
// Shared types and constants of the substring replace stream unit.
`default_nettype none

package srs_pkg;

    localparam int FUNC_W      = 2;
    localparam int CHAR_FIELD_W = 32;
    localparam int IDX_FIELD_W = 4;
    localparam int IDX_LSB     = CHAR_FIELD_W;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 32;
    localparam int M_TUSER_W   = 2;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD_PAT = 2'd0,
        FUNC_LOAD_REP = 2'd1,
        FUNC_TEXT     = 2'd2,
        FUNC_END      = 2'd3
    } func_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_PAT_LEN   = 2'd0,
        CFG_REP_LEN   = 2'd1,
        CFG_LIMIT_EN  = 2'd2,
        CFG_LIMIT_VAL = 2'd3
    } cfg_addr_t;

    typedef struct packed {
        logic shift;
        logic load;
        logic tail;
        logic pat_we;
    } cell_ctl_t;

endpackage

`default_nettype wire

FILE: design/srs_cell.sv
// One window cell: a pending character, its pattern character and their compare.
`default_nettype none

module srs_cell #(
    parameter int CHAR_BITS = 32
) (
    input  wire logic               aclk,
    input  wire srs_pkg::cell_ctl_t ctl,
    input  wire logic [CHAR_BITS-1:0] in_char,
    input  wire logic [CHAR_BITS-1:0] next_char,
    output logic [CHAR_BITS-1:0]    win_char,
    output logic                    eq
);

    logic [CHAR_BITS-1:0] win_reg;
    logic [CHAR_BITS-1:0] pat_reg;

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            win_reg <= in_char;
        end else if (ctl.shift) begin
            win_reg <= next_char;
        end
        if (ctl.pat_we) begin
            pat_reg <= in_char;
        end
    end

    assign win_char = win_reg;
    assign eq       = ((ctl.tail ? in_char : win_reg) == pat_reg);

endmodule

`default_nettype wire

FILE: design/substring_replace_stream_unit.sv
// Top level of the substring replace stream unit: window cell chain and sequencer.
`default_nettype none

// Load items and text beats that cause at most one result do not hold the input.
// An item that causes n results holds the input until its last result is emitted, since
// every result leaves through the single output register at one beat per cycle while
// m_tready allows: a replacement of R characters gives R results, a flush of a window
// holding F characters gives F results. The search window is a chain of MAX_PATTERN
// cells that shifts by one toward the output per emitted character, comparing all cells at once.
// Input beats: s_tuser carries func, s_tdata carries char_value and load_index.
// Output beats: m_tdata carries out_char, m_tuser char_valid and text_done,
// m_tlast marks the final result of an input beat.

`include "assert_macros.svh"

module substring_replace_stream_unit #(
    parameter int MAX_PATTERN     = 16,
    parameter int MAX_REPLACEMENT = 16,
    parameter int CHAR_BITS       = 32
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [srs_pkg::S_TDATA_W-1:0]     s_tdata,  // char_value, load_index, zero pad
    input  wire logic [srs_pkg::FUNC_W-1:0]        s_tuser,  // func
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [srs_pkg::M_TDATA_W-1:0]          m_tdata,  // out_char
    output logic                                   m_tlast,
    output logic [srs_pkg::M_TUSER_W-1:0]          m_tuser,  // char_valid, text_done
    input  wire logic                              cfg_wr_en,
    input  wire logic [srs_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [srs_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam int FILL_W = $clog2(MAX_PATTERN + 1);
    localparam int RCNT_W = $clog2(MAX_REPLACEMENT + 1);
    localparam int RIDX_W = (MAX_REPLACEMENT > 1) ? $clog2(MAX_REPLACEMENT) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DRAIN,
        ST_REPL
    } state_t;

    // configuration
    logic [4:0]  pat_len_reg;
    logic [4:0]  rep_len_reg;
    logic        limit_en_reg;
    logic [15:0] limit_val_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_len_reg   <= '0;
            rep_len_reg   <= '0;
            limit_en_reg  <= 1'b0;
            limit_val_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (srs_pkg::cfg_addr_t'(cfg_addr))
                srs_pkg::CFG_PAT_LEN:   pat_len_reg   <= cfg_wdata[4:0];
                srs_pkg::CFG_REP_LEN:   rep_len_reg   <= cfg_wdata[4:0];
                srs_pkg::CFG_LIMIT_EN:  limit_en_reg  <= cfg_wdata[0];
                srs_pkg::CFG_LIMIT_VAL: limit_val_reg <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    logic [FILL_W-1:0] plen;
    logic [RCNT_W-1:0] rlen;

    assign plen = (32'(pat_len_reg) > MAX_PATTERN) ? FILL_W'(MAX_PATTERN) : FILL_W'(pat_len_reg);
    assign rlen = (32'(rep_len_reg) > MAX_REPLACEMENT) ? RCNT_W'(MAX_REPLACEMENT)
                                                       : RCNT_W'(rep_len_reg);

    // input beat fields
    srs_pkg::func_t           func;
    logic [CHAR_BITS-1:0]     in_char;
    logic [srs_pkg::IDX_FIELD_W-1:0] idx;

    assign func    = srs_pkg::func_t'(s_tuser);
    assign in_char = s_tdata[CHAR_BITS-1:0];
    assign idx     = s_tdata[srs_pkg::IDX_LSB +: srs_pkg::IDX_FIELD_W];

    // sequencer state
    state_t            state_reg, state_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [FILL_W-1:0] rem_reg, rem_next;
    logic              flush_reg, flush_next;
    logic [RIDX_W-1:0] rep_idx_reg, rep_idx_next;
    logic [15:0]       left_reg, left_next;
    logic              open_reg, open_next;

    logic                         m_tvalid_reg, m_tvalid_next;
    logic [srs_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                         m_tlast_reg, m_tlast_next;
    logic                         m_valid_char_reg, m_valid_char_next;
    logic                         m_done_reg, m_done_next;

    logic out_free;
    logic accept;
    logic rep_last;
    logic repl_done;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && out_free;
    assign accept    = s_tvalid && s_tready;
    assign rep_last  = ((32'(rep_idx_reg) + 1) == 32'(rlen));
    assign repl_done = (state_reg == ST_REPL) && out_free && rep_last;

    // replacement store, read through a register addressed from the next state ahead of use
    logic [CHAR_BITS-1:0] rep_mem_reg [MAX_REPLACEMENT];
    logic [CHAR_BITS-1:0] rep_rd_reg;
    logic                 rep_we;
    logic [RIDX_W-1:0]    rep_rd_addr;
    logic [CHAR_BITS-1:0] rep_char;

    assign rep_rd_addr = (state_next == ST_REPL) ? rep_idx_next : '0;

    always_ff @(posedge aclk) begin
        if (rep_we) begin
            rep_mem_reg[RIDX_W'(idx)] <= in_char;
        end
        if (rep_we && (RIDX_W'(idx) == rep_rd_addr)) begin
            rep_rd_reg <= in_char;
        end else begin
            rep_rd_reg <= rep_mem_reg[rep_rd_addr];
        end
    end

    assign rep_char = rep_rd_reg;

    // window cell chain
    logic                 win_shift;
    logic                 win_load_en;
    logic [FILL_W-1:0]    win_load_pos;
    logic                 pat_we_en;
    logic [CHAR_BITS-1:0] win_char [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] eq_vec;
    logic [MAX_PATTERN-1:0] in_pat_vec;
    logic                 match_all;

    for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
        srs_pkg::cell_ctl_t   ctl;
        logic [CHAR_BITS-1:0] next_char;

        assign ctl.shift  = win_shift;
        assign ctl.load   = win_load_en && (win_load_pos == FILL_W'(i));
        assign ctl.tail   = (fill_reg == FILL_W'(i));
        assign ctl.pat_we = pat_we_en && (32'(idx) == i);

        if (i == MAX_PATTERN - 1) begin : g_end
            assign next_char = win_char[i];
        end else begin : g_mid
            assign next_char = win_char[i+1];
        end

        assign in_pat_vec[i] = (FILL_W'(i) < plen);

        srs_cell #(
            .CHAR_BITS(CHAR_BITS)
        ) u_cell (
            .aclk     (aclk),
            .ctl      (ctl),
            .in_char  (in_char),
            .next_char(next_char),
            .win_char (win_char[i]),
            .eq       (eq_vec[i])
        );
    end

    assign match_all = &(eq_vec | ~in_pat_vec);

    // decision for a text beat
    logic [FILL_W-1:0] new_fill;
    logic [FILL_W-1:0] take_cnt;
    logic [15:0]       left_cur;
    logic              replace_hit;

    assign new_fill    = fill_reg + FILL_W'(1);
    assign left_cur    = open_reg ? left_reg : limit_val_reg;
    assign replace_hit = (plen != '0) && (new_fill == plen) && match_all
                         && (!limit_en_reg || (left_cur != '0));

    always_comb begin
        if (plen == '0) begin
            take_cnt = new_fill;
        end else if (new_fill > plen) begin
            take_cnt = new_fill - plen + FILL_W'(1);
        end else if (new_fill == plen) begin
            take_cnt = FILL_W'(1);
        end else begin
            take_cnt = '0;
        end
    end

    always_comb begin
        logic                 emit;
        logic [CHAR_BITS-1:0] emit_char;
        logic                 emit_valid;
        logic                 emit_last;
        logic                 emit_done;

        emit       = 1'b0;
        emit_char  = '0;
        emit_valid = 1'b1;
        emit_last  = 1'b0;
        emit_done  = 1'b0;

        state_next   = state_reg;
        fill_next    = fill_reg;
        rem_next     = rem_reg;
        flush_next   = flush_reg;
        rep_idx_next = rep_idx_reg;
        left_next    = left_reg;
        open_next    = open_reg;

        win_shift    = 1'b0;
        win_load_en  = 1'b0;
        win_load_pos = fill_reg;
        pat_we_en    = 1'b0;
        rep_we       = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (func)
                        srs_pkg::FUNC_LOAD_PAT: begin
                            pat_we_en = (32'(idx) < MAX_PATTERN);
                        end
                        srs_pkg::FUNC_LOAD_REP: begin
                            rep_we = (32'(idx) < MAX_REPLACEMENT);
                        end
                        srs_pkg::FUNC_END: begin
                            open_next = 1'b0;
                            emit      = 1'b1;
                            emit_last = 1'b1;
                            if (fill_reg == '0) begin
                                emit_valid = 1'b0;
                                emit_done  = 1'b1;
                            end else begin
                                emit_char = win_char[0];
                                win_shift = 1'b1;
                                fill_next = fill_reg - FILL_W'(1);
                                if (fill_reg == FILL_W'(1)) begin
                                    emit_done = 1'b1;
                                end else begin
                                    emit_last  = 1'b0;
                                    state_next = ST_DRAIN;
                                    rem_next   = fill_reg - FILL_W'(1);
                                    flush_next = 1'b1;
                                end
                            end
                        end
                        srs_pkg::FUNC_TEXT: begin
                            open_next = 1'b1;
                            left_next = left_cur;
                            if (replace_hit) begin
                                fill_next = '0;
                                if (limit_en_reg) begin
                                    left_next = left_cur - 16'd1;
                                end
                                if (rlen != '0) begin
                                    emit      = 1'b1;
                                    emit_char = rep_char;
                                    emit_last = (rlen == RCNT_W'(1));
                                    if (rlen != RCNT_W'(1)) begin
                                        state_next   = ST_REPL;
                                        rep_idx_next = RIDX_W'(1);
                                    end
                                end
                            end else if (take_cnt == '0) begin
                                win_load_en  = 1'b1;
                                win_load_pos = fill_reg;
                                fill_next    = new_fill;
                            end else begin
                                emit         = 1'b1;
                                emit_char    = (fill_reg == '0) ? in_char : win_char[0];
                                win_shift    = 1'b1;
                                win_load_en  = (fill_reg != '0);
                                win_load_pos = fill_reg - FILL_W'(1);
                                emit_last    = (take_cnt == FILL_W'(1));
                                if (take_cnt != FILL_W'(1)) begin
                                    state_next = ST_DRAIN;
                                    rem_next   = take_cnt - FILL_W'(1);
                                    flush_next = 1'b0;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_DRAIN: begin
                if (out_free) begin
                    emit      = 1'b1;
                    emit_char = win_char[0];
                    win_shift = 1'b1;
                    fill_next = fill_reg - FILL_W'(1);
                    rem_next  = rem_reg - FILL_W'(1);
                    emit_last = (rem_reg == FILL_W'(1));
                    emit_done = (rem_reg == FILL_W'(1)) && flush_reg;
                    if (rem_reg == FILL_W'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_REPL: begin
                if (out_free) begin
                    emit         = 1'b1;
                    emit_char    = rep_char;
                    emit_last    = rep_last;
                    rep_idx_next = rep_idx_reg + RIDX_W'(1);
                    if (emit_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: ;
        endcase

        m_tvalid_next     = m_tvalid_reg && !m_tready;
        m_tdata_next      = m_tdata_reg;
        m_tlast_next      = m_tlast_reg;
        m_valid_char_next = m_valid_char_reg;
        m_done_next       = m_done_reg;
        if (emit) begin
            m_tvalid_next     = 1'b1;
            m_tdata_next      = srs_pkg::M_TDATA_W'(emit_char);
            m_tlast_next      = emit_last;
            m_valid_char_next = emit_valid;
            m_done_next       = emit_done;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            fill_reg         <= '0;
            rem_reg          <= '0;
            flush_reg        <= 1'b0;
            rep_idx_reg      <= '0;
            left_reg         <= '0;
            open_reg         <= 1'b0;
            m_tvalid_reg     <= 1'b0;
            m_tdata_reg      <= '0;
            m_tlast_reg      <= 1'b0;
            m_valid_char_reg <= 1'b0;
            m_done_reg       <= 1'b0;
        end else begin
            state_reg        <= state_next;
            fill_reg         <= fill_next;
            rem_reg          <= rem_next;
            flush_reg        <= flush_next;
            rep_idx_reg      <= rep_idx_next;
            left_reg         <= left_next;
            open_reg         <= open_next;
            m_tvalid_reg     <= m_tvalid_next;
            m_tdata_reg      <= m_tdata_next;
            m_tlast_reg      <= m_tlast_next;
            m_valid_char_reg <= m_valid_char_next;
            m_done_reg       <= m_done_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = {m_done_reg, m_valid_char_reg};

    `SRS_ASSERT_ALWAYS(a_fill_bound, aclk, aresetn, 32'(fill_reg) < MAX_PATTERN)
    `SRS_ASSERT_IMPL(a_drain_count, aclk, aresetn, state_reg == ST_DRAIN, rem_reg != '0)
    `SRS_ASSERT_IMPL(a_repl_empty_window, aclk, aresetn, state_reg == ST_REPL, fill_reg == '0)
    `SRS_ASSERT_IMPL(a_done_is_last, aclk, aresetn, m_tvalid && m_tuser[1], m_tlast)
    `SRS_ASSERT_NEXT(a_repl_ends, aclk, aresetn, repl_done, state_reg == ST_IDLE)

endmodule

`default_nettype wire

FILE: test/substring_replace_stream_unit_tb.sv
// Self-checking stream testbench for the substring replace stream unit.
`timescale 1ns / 100ps

module substring_replace_stream_unit_tb;

    localparam int WIN_MAX     = 16;
    localparam int QUIET_LIMIT = 1000;
    localparam int DRAIN_WAIT  = 20;

    typedef struct packed {
        logic [31:0] ch;
        logic        valid;
        logic        last;
        logic        done;
    } out_beat_t;

    typedef struct packed {
        srs_pkg::func_t func;
        logic [31:0]    ch;
        logic [3:0]     idx;
    } in_item_t;

    logic                           aclk;
    logic                           aresetn   = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [srs_pkg::S_TDATA_W-1:0]  s_tdata   = '0;
    logic [srs_pkg::FUNC_W-1:0]     s_tuser   = '0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [srs_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                           m_tlast;
    logic [srs_pkg::M_TUSER_W-1:0]  m_tuser;
    logic                           cfg_wr_en = 1'b0;
    logic [srs_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [srs_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    substring_replace_stream_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    // predictor state
    logic [4:0]  pat_len   = '0;
    logic [4:0]  rep_len   = '0;
    logic        lim_en    = 1'b0;
    logic [15:0] lim_val   = '0;
    logic [31:0] pat_mem [WIN_MAX];
    logic [31:0] rep_mem [WIN_MAX];
    logic [31:0] win_q [$];
    logic [15:0] repl_left = '0;
    bit          text_open = 1'b0;
    out_beat_t   due_q [$];

    // stimulus state
    in_item_t    pend_q [$];
    in_item_t    next_in;
    logic [31:0] alpha [4];
    logic [31:0] pat_img [WIN_MAX];
    int          gen_plen  = 0;

    int          errors       = 0;
    int          quiet_cycles = 0;
    bit          s_took       = 1'b0;
    int          s_gap        = 0;
    int          s_mode_cnt   = 0;
    bit          s_calm       = 1'b0;
    int          m_stall      = 0;
    int          m_mode_cnt   = 0;
    bit          m_calm       = 1'b0;
    out_beat_t   want;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 20);
    endfunction

    function automatic out_beat_t char_beat(input logic [31:0] c);
        out_beat_t b;
        b = '{ch: c, valid: 1'b1, last: 1'b0, done: 1'b0};
        return b;
    endfunction

    task automatic predict_replace(input srs_pkg::func_t f, input logic [31:0] c,
                                   input logic [3:0] idx);
        out_beat_t run [$];
        out_beat_t b;
        int        plen;
        int        rlen;
        int        k;
        bit        hit;
        plen = (pat_len > WIN_MAX) ? WIN_MAX : int'(pat_len);
        rlen = (rep_len > WIN_MAX) ? WIN_MAX : int'(rep_len);
        case (f)
            srs_pkg::FUNC_LOAD_PAT: pat_mem[idx] = c;
            srs_pkg::FUNC_LOAD_REP: rep_mem[idx] = c;
            srs_pkg::FUNC_END: begin
                while (win_q.size() > 0) run.push_back(char_beat(win_q.pop_front()));
                if (run.size() == 0) run.push_back('{ch: '0, valid: 1'b0, last: 1'b0, done: 1'b0});
                text_open = 1'b0;
            end
            default: begin
                if (!text_open) begin
                    repl_left = lim_val;
                    text_open = 1'b1;
                end
                win_q.push_back(c);
                if (plen == 0) begin
                    while (win_q.size() > 0) run.push_back(char_beat(win_q.pop_front()));
                end else if (win_q.size() > plen) begin
                    while (win_q.size() >= plen) run.push_back(char_beat(win_q.pop_front()));
                end else if (win_q.size() == plen) begin
                    hit = 1'b1;
                    for (k = 0; k < plen; k++)
                        if (win_q[k] != pat_mem[k]) hit = 1'b0;
                    if (hit && (!lim_en || repl_left != 0)) begin
                        for (k = 0; k < rlen; k++) run.push_back(char_beat(rep_mem[k]));
                        win_q.delete();
                        if (lim_en) repl_left = repl_left - 16'd1;
                    end else begin
                        run.push_back(char_beat(win_q.pop_front()));
                    end
                end
            end
        endcase
        for (k = 0; k < run.size(); k++) begin
            b = run[k];
            b.last = (k == run.size() - 1);
            b.done = b.last && (f == srs_pkg::FUNC_END);
            due_q.push_back(b);
        end
    endtask

    // input driver
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_mode_cnt == 0) begin
                s_calm = ($urandom_range(0, 2) == 0);
                s_mode_cnt = $urandom_range(20, 60);
            end else begin
                s_mode_cnt--;
            end
            if (!s_tvalid || s_took) begin
                if (s_gap > 0) begin
                    s_gap--;
                    s_tvalid <= 1'b0;
                end else if (pend_q.size() > 0) begin
                    next_in = pend_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {4'b0, next_in.idx, next_in.ch};
                    s_tuser <= next_in.func;
                    s_gap = s_calm ? 0 : pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result backpressure
    always @(negedge aclk) begin
        if (aresetn) begin
            if (m_mode_cnt == 0) begin
                m_calm = ($urandom_range(0, 2) == 0);
                m_mode_cnt = $urandom_range(20, 60);
            end else begin
                m_mode_cnt--;
            end
            if (m_stall > 0) begin
                m_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (!m_calm && $urandom_range(0, 3) == 0) m_stall = pick_gap();
            end
        end
    end

    // monitor: mirror config, predict on input beats, check output beats
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_took <= 1'b0;
            quiet_cycles <= quiet_cycles + 1;
        end else begin
            s_took <= s_tvalid && s_tready;
            if (cfg_wr_en) begin
                case (cfg_addr)
                    srs_pkg::CFG_PAT_LEN:   pat_len = cfg_wdata[4:0];
                    srs_pkg::CFG_REP_LEN:   rep_len = cfg_wdata[4:0];
                    srs_pkg::CFG_LIMIT_EN:  lim_en  = cfg_wdata[0];
                    srs_pkg::CFG_LIMIT_VAL: lim_val = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                predict_replace(srs_pkg::func_t'(s_tuser), s_tdata[31:0],
                                s_tdata[srs_pkg::IDX_LSB +: srs_pkg::IDX_FIELD_W]);
            if (m_tvalid && m_tready) begin
                if (due_q.size() == 0) begin
                    $display("%0t: unexpected beat out_char=%h tuser=%b tlast=%b",
                             $time, m_tdata, m_tuser, m_tlast);
                    errors++;
                end else begin
                    want = due_q.pop_front();
                    if (m_tdata !== want.ch) begin
                        $display("%0t: out_char expected %h actual %h", $time, want.ch, m_tdata);
                        errors++;
                    end
                    if (m_tuser[0] !== want.valid) begin
                        $display("%0t: char_valid expected %b actual %b",
                                 $time, want.valid, m_tuser[0]);
                        errors++;
                    end
                    if (m_tlast !== want.last) begin
                        $display("%0t: tlast expected %b actual %b", $time, want.last, m_tlast);
                        errors++;
                    end
                    if (m_tuser[1] !== want.done) begin
                        $display("%0t: text_done expected %b actual %b",
                                 $time, want.done, m_tuser[1]);
                        errors++;
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge aclk);
        $display("substring_replace_stream_unit test failed");
        $finish;
    end

    task automatic push_item(input srs_pkg::func_t f, input logic [31:0] c,
                             input logic [3:0] idx);
        pend_q.push_back('{func: f, ch: c, idx: idx});
        if (f == srs_pkg::FUNC_LOAD_PAT) pat_img[idx] = c;
    endtask

    task automatic push_text(input logic [31:0] c);
        push_item(srs_pkg::FUNC_TEXT, c, 4'($urandom));
    endtask

    task automatic push_end();
        push_item(srs_pkg::FUNC_END, $urandom, 4'($urandom));
    endtask

    task automatic push_copy(input int n);
        int k;
        for (k = 0; k < n; k++) push_text(pat_img[k]);
    endtask

    task automatic set_cfg(input logic [15:0] pl, input logic [15:0] rl,
                           input logic [15:0] le, input logic [15:0] lv);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= srs_pkg::CFG_PAT_LEN;
        cfg_wdata <= pl;
        @(negedge aclk);
        cfg_addr  <= srs_pkg::CFG_REP_LEN;
        cfg_wdata <= rl;
        @(negedge aclk);
        cfg_addr  <= srs_pkg::CFG_LIMIT_EN;
        cfg_wdata <= le;
        @(negedge aclk);
        cfg_addr  <= srs_pkg::CFG_LIMIT_VAL;
        cfg_wdata <= lv;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        gen_plen = (pl[4:0] > WIN_MAX) ? WIN_MAX : int'(pl[4:0]);
    endtask

    task automatic wait_idle();
        while (pend_q.size() != 0 || s_tvalid || due_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(negedge aclk);
    endtask

    // mostly whole or broken pattern copies, with noise, loads and text ends mixed in
    task automatic random_text(input int count);
        int n;
        int r;
        int cut;
        n = 0;
        while (n < count) begin
            r = $urandom_range(0, 99);
            if (r < 35 && gen_plen > 0) begin
                push_copy(gen_plen);
                n += gen_plen;
            end else if (r < 50 && gen_plen > 1) begin
                cut = $urandom_range(1, gen_plen - 1);
                push_copy(cut);
                push_text(alpha[$urandom_range(0, 3)]);
                n += cut + 1;
            end else if (r < 75) begin
                push_text(alpha[$urandom_range(0, 3)]);
                n++;
            end else if (r < 85) begin
                push_text($urandom);
                n++;
            end else if (r < 92) begin
                push_end();
                n++;
            end else if (r < 96) begin
                push_item(srs_pkg::FUNC_LOAD_PAT, alpha[$urandom_range(0, 3)], 4'($urandom));
                n++;
            end else begin
                push_item(srs_pkg::FUNC_LOAD_REP, $urandom, 4'($urandom));
                n++;
            end
        end
    endtask

    initial begin
        int k;
        for (k = 0; k < 4; k++) alpha[k] = $urandom;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // pass-through with extreme characters and a bare end marker
        set_cfg(16'd0, 16'd3, 16'd0, 16'd0);
        for (k = 0; k < WIN_MAX; k++) begin
            push_item(srs_pkg::FUNC_LOAD_PAT, alpha[$urandom_range(0, 3)], 4'(k));
            push_item(srs_pkg::FUNC_LOAD_REP, $urandom, 4'(k));
        end
        push_end();
        push_text(32'h0000_0000);
        push_text(32'hFFFF_FFFF);
        push_text(32'hA5A5_5A5A);
        push_end();
        wait_idle();

        // full-length replacement, near misses, non-empty flush
        set_cfg(16'd3, 16'd16, 16'd0, 16'd0);
        push_copy(3);
        push_text(pat_img[0]);
        push_text(pat_img[1]);
        push_text(~pat_img[2]);
        push_copy(3);
        push_text(pat_img[0]);
        push_end();
        wait_idle();

        // deletion under a limit of one, limit reloaded on the next text
        set_cfg(16'd2, 16'd0, 16'd1, 16'd1);
        push_copy(2);
        push_copy(2);
        push_end();
        push_copy(2);
        push_end();
        wait_idle();

        set_cfg(16'd5, 16'd2, 16'd0, 16'd0);
        random_text(20);
        push_end();
        wait_idle();

        set_cfg(16'd1, 16'd16, 16'd0, 16'd0);
        random_text(20);
        push_end();
        wait_idle();

        // limit zero at the largest pattern; leave the text open with twelve characters in the window
        set_cfg(16'd16, 16'd1, 16'd1, 16'd0);
        random_text(20);
        push_end();
        push_copy(12);
        wait_idle();

        // shrink the pattern under a partly filled window
        set_cfg(16'd3, 16'd4, 16'd1, 16'd2);
        random_text(20);
        push_end();
        wait_idle();

        // oversized lengths saturate; largest limit
        set_cfg(16'd31, 16'd20, 16'd1, 16'hFFFF);
        random_text(20);
        push_end();
        wait_idle();

        set_cfg(16'd2, 16'd0, 16'd0, 16'd7);
        random_text(20);
        push_end();
        wait_idle();

        set_cfg(16'd0, 16'd5, 16'd0, 16'd0);
        random_text(15);
        push_end();
        wait_idle();

        if (errors == 0) begin
            $display("substring_replace_stream_unit test passed");
        end else begin
            $display("substring_replace_stream_unit test failed");
        end
        $finish;
    end

endmodule
